// ----- sv/etf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package etf_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int COORD_BITS = 12;
   localparam int ITER_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   // magnitude of pixel * span
   localparam int NUM_BITS   = COORD_BITS + WORD_BITS + 1;
   localparam int STEP_BITS  = $clog2(NUM_BITS + 1);
   localparam int SUM_BITS   = 48;

   localparam logic [1:0] MODE_MANDEL = 2'd0;
   localparam logic [1:0] MODE_JULIA  = 2'd1;
   localparam logic [1:0] MODE_SHIP   = 2'd2;

   localparam longint JULIA_CR_L = ((64'sd57 <<< FRAC_BITS) + 64'sd100) / 64'sd200;
   localparam longint JULIA_CI_L = ((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
   localparam logic signed [WORD_BITS-1:0] JULIA_CR = WORD_BITS'(JULIA_CR_L);
   localparam logic signed [WORD_BITS-1:0] JULIA_CI = WORD_BITS'(JULIA_CI_L);

   // |z|^2 >= 4.0 on the exact 2F-fraction product sum
   localparam logic [63:0] ESCAPE_MAG = 64'd1 << (2 * FRAC_BITS + 2);

   typedef enum logic [2:0] {
      CSR_X_MIN,
      CSR_X_MAX,
      CSR_Y_MIN,
      CSR_Y_MAX,
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_MAX_ITER,
      CSR_MODE
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LOAD,
      ST_DIV,
      ST_MAP,
      ST_ITER_MUL,
      ST_ITER_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  acc;
      logic [SIZE_BITS-1:0] dvsr;
      logic                 neg;
   } div_state_type;

   function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'(64'sd2147483647);
      lo = -SUM_BITS'(64'sd2147483648);
      if (v > hi) begin
         return hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORD_BITS-1:0];
      end else begin
         return v[WORD_BITS-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- sv/etf_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one restoring division step per cycle
module etf_div_cell (
   input  wire                         clock,
   input  wire etf_pkg::div_state_type cell_in,
   output etf_pkg::div_state_type      cell_out
);
   import etf_pkg::*;

   div_state_type        cell_ff;
   div_state_type        cell_in_step;
   logic [SIZE_BITS:0]   trial;
   logic [SIZE_BITS:0]   diff;
   logic                 fits;

   always_comb begin
      trial = {cell_in.rem, cell_in.acc[NUM_BITS-1]};
      diff  = trial - {1'b0, cell_in.dvsr};
      fits  = trial >= {1'b0, cell_in.dvsr};
      cell_in_step      = cell_in;
      cell_in_step.rem  = fits ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
      cell_in_step.acc  = {cell_in.acc[NUM_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_step;
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

// ----- sv/escape_time_fractal_iterator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow from req accept to rsp valid: ST_SCALE, ST_LOAD and 45 divider steps, ST_MAP, then
//   ST_ITER_MUL and ST_ITER_UPD for each escape test until the item escapes or passes max_iter,
//   then ST_DONE hands the result off. The divider ring and the escape loop set the latency.
// One item at a time; the next item is taken only after the previous result lands in the
//   output register, and ST_DONE waits there while a stalled result still holds that register.
// Reset: synchronous, active high; restores default window and mode, empties pipeline.
module escape_time_fractal_iterator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // pixel_col[11:0], pixel_row[23:12]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // out_col[11:0], out_row[23:12], iter_count[39:24]
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [31:0] csr_wdata
);
   import etf_pkg::*;

   // x division ends in cell 0 when the step count is odd
   localparam bit X_IN_CELL0 = (NUM_BITS % 2) == 1;

   // config registers
   logic [WORD_BITS-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [ITER_BITS-1:0] max_iter_ff;
   logic [1:0]           mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= 32'hE000_0000;
         x_max_ff    <= 32'h2000_0000;
         y_min_ff    <= 32'hE000_0000;
         y_max_ff    <= 32'h2000_0000;
         width_ff    <= SIZE_BITS'(800);
         height_ff   <= SIZE_BITS'(800);
         max_iter_ff <= ITER_BITS'(50);
         mode_ff     <= MODE_MANDEL;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_X_MIN:    x_min_ff    <= csr_wdata;
            CSR_X_MAX:    x_max_ff    <= csr_wdata;
            CSR_Y_MIN:    y_min_ff    <= csr_wdata;
            CSR_Y_MAX:    y_max_ff    <= csr_wdata;
            CSR_WIDTH:    width_ff    <= csr_wdata[SIZE_BITS-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_BITS-1:0];
            CSR_MODE:     mode_ff     <= csr_wdata[1:0];
            default:      ;
         endcase
      end
   end

   // control
   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [ITER_BITS:0]   n_ff, n_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;

   // payload
   logic [COORD_BITS-1:0]       col_ff, col_in, row_ff, row_in;
   logic signed [NUM_BITS:0]    prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [WORD_BITS-1:0] zr_ff, zr_in, zi_ff, zi_in, cr_ff, cr_in, ci_ff, ci_in;
   logic                        ship_ff, ship_in;
   logic [63:0]                 aa_ff, aa_in, bb_ff, bb_in;
   logic signed [63:0]          ab_ff, ab_in;
   logic [ITER_BITS-1:0]        count_ff, count_in;
   logic [39:0]                 rsp_data_ff, rsp_data_in;

   // divider ring: two cells swap the x and y divisions every cycle
   div_state_type cell0_in, cell0_out, cell1_in, cell1_out;
   div_state_type x_init, y_init, x_res, y_res;
   logic          div_load;

   etf_div_cell u_cell0 (.clock(clock), .cell_in(cell0_in), .cell_out(cell0_out));
   etf_div_cell u_cell1 (.clock(clock), .cell_in(cell1_in), .cell_out(cell1_out));

   logic signed [WORD_BITS:0]   span_x, span_y;
   logic signed [NUM_BITS:0]    mag_x, mag_y;
   logic signed [NUM_BITS:0]    q_x, q_y;
   logic signed [SUM_BITS-1:0]  sum_x, sum_y;
   logic signed [WORD_BITS-1:0] px, py;
   logic signed [WORD_BITS:0]   a_op, b_op;
   logic signed [65:0]          aa_full, bb_full, ab_full;
   logic signed [64:0]          sq_diff;
   logic signed [SUM_BITS-1:0]  re_sum, im_sum;
   logic [63:0]                 mag;

   always_comb begin
      span_x = $signed({x_max_ff[WORD_BITS-1], x_max_ff})
             - $signed({x_min_ff[WORD_BITS-1], x_min_ff});
      span_y = $signed({y_max_ff[WORD_BITS-1], y_max_ff})
             - $signed({y_min_ff[WORD_BITS-1], y_min_ff});
      prod_x_in = $signed({1'b0, col_ff}) * span_x;
      prod_y_in = $signed({1'b0, row_ff}) * span_y;

      mag_x = prod_x_ff[NUM_BITS] ? -prod_x_ff : prod_x_ff;
      mag_y = prod_y_ff[NUM_BITS] ? -prod_y_ff : prod_y_ff;
      x_init.rem  = '0;
      x_init.acc  = mag_x[NUM_BITS-1:0];
      x_init.dvsr = (width_ff == '0) ? SIZE_BITS'(1) : width_ff;
      x_init.neg  = prod_x_ff[NUM_BITS];
      y_init.rem  = '0;
      y_init.acc  = mag_y[NUM_BITS-1:0];
      y_init.dvsr = (height_ff == '0) ? SIZE_BITS'(1) : height_ff;
      y_init.neg  = prod_y_ff[NUM_BITS];

      div_load = (state_ff == ST_LOAD);
      cell0_in = div_load ? x_init : cell1_out;
      cell1_in = div_load ? y_init : cell0_out;
      x_res    = X_IN_CELL0 ? cell0_out : cell1_out;
      y_res    = X_IN_CELL0 ? cell1_out : cell0_out;

      // quotient rounds toward zero: restore sign, add the edge, saturate
      q_x   = x_res.neg ? -$signed({1'b0, x_res.acc}) : $signed({1'b0, x_res.acc});
      q_y   = y_res.neg ? -$signed({1'b0, y_res.acc}) : $signed({1'b0, y_res.acc});
      sum_x = SUM_BITS'(q_x) + SUM_BITS'($signed(x_min_ff));
      sum_y = SUM_BITS'(q_y) + SUM_BITS'($signed(y_min_ff));
      px    = sat_word(sum_x);
      py    = sat_word(sum_y);

      // burning ship folds both parts to their magnitudes
      a_op    = 33'(zr_ff);
      b_op    = 33'(zi_ff);
      if (ship_ff && zr_ff[WORD_BITS-1]) a_op = -33'(zr_ff);
      if (ship_ff && zi_ff[WORD_BITS-1]) b_op = -33'(zi_ff);
      aa_full = a_op * a_op;
      bb_full = b_op * b_op;
      ab_full = a_op * b_op;
      aa_in   = aa_full[63:0];
      bb_in   = bb_full[63:0];
      ab_in   = ab_full[63:0];

      mag     = aa_ff + bb_ff;
      sq_diff = $signed({1'b0, aa_ff}) - $signed({1'b0, bb_ff});
      re_sum  = SUM_BITS'(sq_diff >>> FRAC_BITS) + SUM_BITS'(cr_ff);
      im_sum  = SUM_BITS'(ab_ff >>> (FRAC_BITS - 1)) + SUM_BITS'(ci_ff);
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      n_in        = n_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      zr_in       = zr_ff;
      zi_in       = zi_ff;
      cr_in       = cr_ff;
      ci_in       = ci_ff;
      ship_in     = ship_ff;
      count_in    = count_ff;
      rsp_load    = 1'b0;
      req_tready  = (state_ff == ST_IDLE);
      rsp_data_in = {count_ff, row_ff, col_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               col_in   = req_tdata[COORD_BITS-1:0];
               row_in   = req_tdata[2*COORD_BITS-1:COORD_BITS];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_LOAD;
         ST_LOAD: begin
            step_in  = STEP_BITS'(NUM_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == STEP_BITS'(1)) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            ship_in = (mode_ff == MODE_SHIP);
            n_in    = (ITER_BITS + 1)'(1);
            if (mode_ff == MODE_MANDEL || mode_ff == MODE_SHIP) begin
               cr_in = px;
               ci_in = py;
               zr_in = '0;
               zi_in = '0;
            end else begin
               cr_in = JULIA_CR;
               ci_in = JULIA_CI;
               zr_in = px;
               zi_in = py;
            end
            state_in = ST_ITER_MUL;
         end
         ST_ITER_MUL: begin
            if (n_ff > {1'b0, max_iter_ff}) begin
               count_in = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_ITER_UPD;
            end
         end
         ST_ITER_UPD: begin
            if (mag >= ESCAPE_MAG) begin
               count_in = n_ff[ITER_BITS-1:0];
               state_in = ST_DONE;
            end else begin
               zr_in    = sat_word(re_sum);
               zi_in    = sat_word(im_sum);
               n_in     = n_ff + (ITER_BITS + 1)'(1);
               state_in = ST_ITER_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      row_ff    <= row_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      ship_ff   <= ship_in;
      aa_ff     <= aa_in;
      bb_ff     <= bb_in;
      ab_ff     <= ab_in;
      count_ff  <= count_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- sv/etf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module etf_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // one item in flight: input closes right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind escape_time_fractal_iterator etf_checker u_etf_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire
